// ===== design/kocs_pkg.sv =====
// Package for the keyed ordered chunk store.
// Holds the transaction payload types, the stored entry type and the command and status codes.
// Depends on nothing; used by kocs_slot_ram and keyed_ordered_chunk_store_core.
`timescale 1ns / 1ps

package kocs_pkg;

  // Command codes
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_TAKE = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_NONE = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // Input transaction
  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] inode;
    logic [31:0] chunk_index;
    logic [63:0] payload;
    logic        dirty_in;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_inode;
    logic [31:0] out_chunk_index;
    logic [63:0] out_payload;
    logic        dirty_out;
    logic [4:0]  occupancy;
  } out_t;

  // One stored slot
  typedef struct packed {
    logic [31:0] inode;
    logic [31:0] chunk;
    logic [63:0] handle;
    logic        dirty;
  } entry_t;

endpackage

// ===== design/kocs_slot_ram.sv =====
// Slot memory of the chunk store: one write port, one read port with registered read data.
// Depends on kocs_pkg for the entry type.
`timescale 1ns / 1ps

module kocs_slot_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  kocs_pkg::entry_t  wdata,
  input  logic [AW-1:0]     raddr,
  output kocs_pkg::entry_t  rdata
);
  import kocs_pkg::*;

  entry_t mem [DEPTH];

  // Storage is not cleared; only read data from slots below the fill count is ever used
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/keyed_ordered_chunk_store_core.sv =====
// Keyed ordered chunk store: insertion-ordered slots, one key comparator reused per slot.
// Sequencing: one slot read per key compare and one read+write per shift step over the N entries
//   held; cmd 3 and empty pop/take go straight to completion.
// Throughput: one transaction in flight; in_ready is high only while the sequencer is idle.
// Reset: synchronous, clears fill count, sequencer and output valid; slot RAM is not cleared.
// Depends on kocs_pkg and kocs_slot_ram.
`timescale 1ns / 1ps

module keyed_ordered_chunk_store_core #(
  parameter int CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  kocs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output kocs_pkg::out_t out_data
);
  import kocs_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SCAN_RD  = 9'b000000010,
    S_SCAN_CMP = 9'b000000100,
    S_POP_RD   = 9'b000001000,
    S_POP_CAP  = 9'b000010000,
    S_SH_RD    = 9'b000100000,
    S_SH_WR    = 9'b001000000,
    S_APPEND   = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_t;

  state_t      state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  in_t         req, req_next;
  out_t        res, res_next;
  out_t        out_reg, out_reg_next;
  logic        out_vld, out_vld_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;

  logic [CW-1:0] idx_inc;
  logic          key_hit;
  logic          last_slot;
  logic [CW+4:0] count_ext;

  kocs_slot_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Shared key comparator and index step
  assign idx_inc   = idx + CW'(1);
  assign last_slot = (idx_inc >= count);
  assign key_hit   = (ram_rdata.inode == req.inode) && (ram_rdata.chunk == req.chunk_index);
  assign count_ext = {5'b0, count};

  assign in_ready  = (state == S_IDLE);
  assign out_valid = out_vld;
  assign out_data  = out_reg;

  // Sequencer
  always_comb begin
    state_next   = state;
    count_next   = count;
    idx_next     = idx;
    req_next     = req;
    res_next     = res;
    out_reg_next = out_reg;
    out_vld_next = out_vld && !out_ready;
    ram_we       = 1'b0;
    ram_waddr    = idx[AW-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = idx[AW-1:0];

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          req_next = in_data;
          res_next = '0;
          res_next.status = STATUS_NONE;
          idx_next = '0;
          case (in_data.command)
            CMD_PUSH: state_next = (count == '0) ? S_APPEND : S_SCAN_RD;
            CMD_POP:  state_next = (count == '0) ? S_DONE : S_POP_RD;
            CMD_TAKE: state_next = (count == '0) ? S_DONE : S_SCAN_RD;
            default:  state_next = S_DONE;
          endcase
        end
      end

      // Read slot idx for the key compare
      S_SCAN_RD: begin
        state_next = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (key_hit) begin
          if (req.command == CMD_TAKE) begin
            res_next.status          = STATUS_OK;
            res_next.out_inode       = ram_rdata.inode;
            res_next.out_chunk_index = ram_rdata.chunk;
            res_next.out_payload     = ram_rdata.handle;
            res_next.dirty_out       = ram_rdata.dirty;
          end
          state_next = S_SH_RD;
        end else if (last_slot) begin
          state_next = (req.command == CMD_PUSH) ? S_APPEND : S_DONE;
        end else begin
          idx_next   = idx_inc;
          state_next = S_SCAN_RD;
        end
      end

      S_POP_RD: begin
        state_next = S_POP_CAP;
      end

      S_POP_CAP: begin
        res_next.status          = STATUS_OK;
        res_next.out_inode       = ram_rdata.inode;
        res_next.out_chunk_index = ram_rdata.chunk;
        res_next.out_payload     = ram_rdata.handle;
        res_next.dirty_out       = ram_rdata.dirty;
        state_next               = S_SH_RD;
      end

      // Compaction: move slot idx+1 down to idx until the tail
      S_SH_RD: begin
        ram_raddr = idx_inc[AW-1:0];
        if (last_slot) begin
          count_next = count - CW'(1);
          state_next = (req.command == CMD_PUSH) ? S_APPEND : S_DONE;
        end else begin
          state_next = S_SH_WR;
        end
      end

      S_SH_WR: begin
        ram_we     = 1'b1;
        idx_next   = idx_inc;
        state_next = S_SH_RD;
      end

      S_APPEND: begin
        ram_waddr       = count[AW-1:0];
        ram_wdata.inode  = req.inode;
        ram_wdata.chunk  = req.chunk_index;
        ram_wdata.handle = req.payload;
        ram_wdata.dirty  = req.dirty_in;
        if (count >= CW'(CAPACITY)) begin
          res_next.status = STATUS_FULL;
        end else begin
          ram_we          = 1'b1;
          count_next      = count + CW'(1);
          res_next.status = STATUS_OK;
        end
        state_next = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_vld || out_ready) begin
          out_reg_next           = res;
          out_reg_next.occupancy = count_ext[4:0];
          out_vld_next           = 1'b1;
          state_next             = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      out_vld <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      out_vld <= out_vld_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    idx     <= idx_next;
    req     <= req_next;
    res     <= res_next;
    out_reg <= out_reg_next;
  end

  // Fill count stays within capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // Sequencer is busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second transaction while busy");

  // Compaction never writes at or beyond the last held slot
  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SH_WR |-> idx_inc < count)
    else $error("shift step past the tail");

  // A successful append grows the count by one
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    state == S_APPEND && count < CW'(CAPACITY) |=> count == $past(count) + CW'(1))
    else $error("append did not grow the fill count");

  // A new result only comes from the completion state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_vld) |-> $past(state == S_DONE))
    else $error("result loaded outside completion");

endmodule
